FILE: hw/rtl/c32mp_pkg.sv
// Shared types, preset table and the byte update function of the CRC-32 engine.
package c32mp_pkg;

  // Preset numbers as written to the mode register.
  typedef enum logic [2:0] {
    ModeIsoHdlc  = 3'd0,
    ModeIscsi    = 3'd1,
    ModeBzip2    = 3'd2,
    ModeJamcrc   = 3'd3,
    ModeMpeg2    = 3'd4,
    ModeCdromEdc = 3'd5
  } crc_mode_e;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned ModeWidth = 3;

  localparam logic [CrcWidth-1:0] AllOnes     = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] AllZeros    = 32'h0000_0000;
  localparam logic [CrcWidth-1:0] PolyIeeeRef = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0] PolyIeee    = 32'h04C1_1DB7;
  localparam logic [CrcWidth-1:0] PolyCastRef = 32'h82F6_3B78;
  localparam logic [CrcWidth-1:0] PolyEdcRef  = 32'hD801_8001;

  // One preset: the polynomial (in reflected form when refl is set), bit order,
  // initial value and final XOR.
  typedef struct packed {
    logic [CrcWidth-1:0] poly;
    logic                refl;
    logic [CrcWidth-1:0] init;
    logic [CrcWidth-1:0] xorout;
  } preset_t;

  // Decode the mode register. The two unused codes fall back to CD-ROM-EDC.
  function automatic preset_t preset_of(logic [ModeWidth-1:0] mode);
    preset_t p;
    unique case (crc_mode_e'(mode))
      ModeIsoHdlc: p = '{poly: PolyIeeeRef, refl: 1'b1, init: AllOnes,  xorout: AllOnes};
      ModeIscsi:   p = '{poly: PolyCastRef, refl: 1'b1, init: AllOnes,  xorout: AllOnes};
      ModeBzip2:   p = '{poly: PolyIeee,    refl: 1'b0, init: AllOnes,  xorout: AllOnes};
      ModeJamcrc:  p = '{poly: PolyIeeeRef, refl: 1'b1, init: AllOnes,  xorout: AllZeros};
      ModeMpeg2:   p = '{poly: PolyIeee,    refl: 1'b0, init: AllOnes,  xorout: AllZeros};
      default:     p = '{poly: PolyEdcRef,  refl: 1'b1, init: AllZeros, xorout: AllZeros};
    endcase
    return p;
  endfunction

  // Absorb one byte into the running register, one bit per step.
  function automatic logic [CrcWidth-1:0] absorb_byte(preset_t p, logic [CrcWidth-1:0] crc,
                                                      logic [ByteWidth-1:0] data);
    logic [CrcWidth-1:0] c;
    c = crc;
    if (p.refl) begin
      c = c ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int k = 0; k < ByteWidth; k++) begin
        c = (c >> 1) ^ (c[0] ? p.poly : AllZeros);
      end
    end else begin
      c = c ^ {data, {(CrcWidth-ByteWidth){1'b0}}};
      for (int k = 0; k < ByteWidth; k++) begin
        c = (c << 1) ^ (c[CrcWidth-1] ? p.poly : AllZeros);
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/c32mp_byte_update.sv
// Byte-wide CRC update: the XOR network for the selected preset, plus the
// final XOR that turns the updated register into the finished CRC.
module c32mp_byte_update (
  input  c32mp_pkg::preset_t                   preset_i,
  input  logic [c32mp_pkg::CrcWidth-1:0]       crc_i,
  input  logic [c32mp_pkg::ByteWidth-1:0]      data_byte_i,
  input  logic                                 has_byte_i,
  output logic [c32mp_pkg::CrcWidth-1:0]       crc_next_o,
  output logic [c32mp_pkg::CrcWidth-1:0]       crc_final_o
);

  // An item without a byte leaves the register as it is.
  always_comb begin
    if (has_byte_i) begin
      crc_next_o = c32mp_pkg::absorb_byte(preset_i, crc_i, data_byte_i);
    end else begin
      crc_next_o = crc_i;
    end
  end

  // The finished CRC after the preset's output inversion.
  assign crc_final_o = crc_next_o ^ preset_i.xorout;

endmodule

FILE: hw/rtl/c32mp_out_reg.sv
// Result register: holds one finished CRC until the downstream side takes it.
module c32mp_out_reg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [c32mp_pkg::CrcWidth-1:0]   data_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [c32mp_pkg::CrcWidth-1:0]   data_o
);

  logic                           valid_d, valid_q;
  logic [c32mp_pkg::CrcWidth-1:0] data_q;

  // A load refills the slot; otherwise a taken beat empties it.
  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/crc32_multi_preset_engine_unit.sv
// Byte-stream CRC-32 engine with six presets (ISO-HDLC, ISCSI, BZIP2, JAMCRC,
// MPEG-2, CD-ROM-EDC) picked by the mode register; codes 6 and 7 act as
// CD-ROM-EDC. It takes one input beat per clock cycle while no closing beat
// waits on a full result slot, with the byte update of the selected preset done
// by a combinational XOR network between the input register and the running CRC
// register. The beat that closes a message presents its CRC on the result port
// through the input register and then the result register, which lets new input
// beats in while the result waits. Writing the mode reloads the running CRC with
// the new preset's initial value; write it only while idle.
module crc32_multi_preset_engine_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [c32mp_pkg::ModeWidth-1:0]   cfg_crc_mode_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [c32mp_pkg::ByteWidth-1:0]   data_byte_i,
  input  logic                              has_byte_i,
  input  logic                              last_item_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [c32mp_pkg::CrcWidth-1:0]    crc_value_o
);

  logic [c32mp_pkg::ModeWidth-1:0] mode_q;
  logic [c32mp_pkg::CrcWidth-1:0]  crc_d, crc_q;
  logic                            in_valid_q;
  logic [c32mp_pkg::ByteWidth-1:0] data_byte_q;
  logic                            has_byte_q;
  logic                            last_item_q;
  c32mp_pkg::preset_t              preset;
  c32mp_pkg::preset_t              cfg_preset;
  logic [c32mp_pkg::CrcWidth-1:0]  crc_next;
  logic [c32mp_pkg::CrcWidth-1:0]  crc_final;
  logic                            cfg_fire;
  logic                            stage_fire;

  assign preset     = c32mp_pkg::preset_of(mode_q);
  assign cfg_preset = c32mp_pkg::preset_of(cfg_crc_mode_i);

  // The held beat proceeds unless it closes a message and the result slot stays full.
  assign stage_fire  = in_valid_q && (!last_item_q || !out_valid_o || out_ready_i);
  assign in_ready_o  = !in_valid_q || stage_fire;
  assign cfg_ready_o = !in_valid_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_byte_q <= data_byte_i;
      has_byte_q  <= has_byte_i;
      last_item_q <= last_item_i;
    end
  end

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= c32mp_pkg::ModeWidth'(c32mp_pkg::ModeIsoHdlc);
    end else if (cfg_fire) begin
      mode_q <= cfg_crc_mode_i;
    end
  end

  c32mp_byte_update u_update (
    .preset_i    (preset),
    .crc_i       (crc_q),
    .data_byte_i (data_byte_q),
    .has_byte_i  (has_byte_q),
    .crc_next_o  (crc_next),
    .crc_final_o (crc_final)
  );

  // Running CRC: reloaded on a mode write and at the end of each message.
  always_comb begin
    crc_d = crc_q;
    if (cfg_fire) begin
      crc_d = cfg_preset.init;
    end else if (stage_fire) begin
      crc_d = last_item_q ? preset.init : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= c32mp_pkg::AllOnes;
    end else begin
      crc_q <= crc_d;
    end
  end

  c32mp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (stage_fire && last_item_q),
    .data_i  (crc_final),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (crc_value_o)
  );

  // A mode write leaves the running CRC at the new preset's initial value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> crc_q == preset.init)
    else $error("CRC register not reloaded after mode write");

  // A closing beat fills the result slot on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && last_item_q |=> out_valid_o)
    else $error("closing beat produced no result");

  // A closing beat reloads the running CRC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && last_item_q |=> crc_q == preset.init)
    else $error("CRC register not reloaded at end of message");

  // The input side only stalls while a held closing beat waits on a full result slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && last_item_q && out_valid_o)
    else $error("input stalled without a blocked closing beat");

endmodule

FILE: tb/crc32_multi_preset_engine_unit_checker.sv
`timescale 1ns / 100ps

// Watches the mode, input and result channels of the CRC-32 engine, predicts the
// CRC of every closed message and compares it with the result beats in order.
module crc32_multi_preset_engine_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_crc_mode_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] crc_value_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          checked_o
);

  // Polynomial (reflected when lsb_first is set), start value and final XOR.
  typedef struct packed {
    logic [31:0] gen_poly;
    logic        lsb_first;
    logic [31:0] start_value;
    logic [31:0] final_xor;
  } crc_setup_t;

  logic [2:0]  active_mode;
  logic [31:0] running_crc;
  logic [31:0] wanted_crc;
  crc_setup_t  setup;
  logic [31:0] crc_expect_q[$];
  int          mismatches = 0;
  int          crcs_checked = 0;

  assign fail_count_o = mismatches;
  assign checked_o    = crcs_checked;

  // The two spare mode codes behave as CD-ROM-EDC.
  function automatic crc_setup_t crc_setup_for(logic [2:0] mode);
    crc_setup_t s;
    case (mode)
      c32mp_pkg::ModeIsoHdlc: s = '{32'hEDB8_8320, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      c32mp_pkg::ModeIscsi:   s = '{32'h82F6_3B78, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      c32mp_pkg::ModeBzip2:   s = '{32'h04C1_1DB7, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      c32mp_pkg::ModeJamcrc:  s = '{32'hEDB8_8320, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000};
      c32mp_pkg::ModeMpeg2:   s = '{32'h04C1_1DB7, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000};
      default:                s = '{32'hD801_8001, 1'b1, 32'h0000_0000, 32'h0000_0000};
    endcase
    return s;
  endfunction

  // Bitwise division step for one message byte.
  function automatic logic [31:0] crc_fold_byte(crc_setup_t s, logic [31:0] crc,
                                                logic [7:0] b);
    logic [31:0] r;
    r = crc;
    if (s.lsb_first) begin
      r = r ^ {24'h00_0000, b};
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ s.gen_poly) : (r >> 1);
      end
    end else begin
      r = r ^ {b, 24'h00_0000};
      for (int i = 0; i < 8; i++) begin
        r = r[31] ? ((r << 1) ^ s.gen_poly) : (r << 1);
      end
    end
    return r;
  endfunction

  // Track mode writes and input beats, then score result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_mode = c32mp_pkg::ModeIsoHdlc;
      setup       = crc_setup_for(active_mode);
      running_crc = setup.start_value;
      crc_expect_q.delete();
      pending_o <= 0;
    end else begin
      // A result beat is compared with the oldest predicted CRC.
      if (out_valid_i && out_ready_i) begin
        if (crc_expect_q.size() == 0) begin
          $error("crc_value: result beat with none expected, actual %h", crc_value_i);
          mismatches++;
        end else begin
          wanted_crc = crc_expect_q.pop_front();
          crcs_checked++;
          if (crc_value_i !== wanted_crc) begin
            $error("crc_value: expected %h, actual %h", wanted_crc, crc_value_i);
            mismatches++;
          end
        end
      end

      // A mode write reloads the running CRC of the new preset.
      if (cfg_valid_i && cfg_ready_i) begin
        active_mode = cfg_crc_mode_i;
        setup       = crc_setup_for(active_mode);
        running_crc = setup.start_value;
      end

      // An input beat folds in its byte and may close the message.
      if (in_valid_i && in_ready_i) begin
        setup = crc_setup_for(active_mode);
        if (has_byte_i) begin
          running_crc = crc_fold_byte(setup, running_crc, data_byte_i);
        end
        if (last_item_i) begin
          crc_expect_q.push_back(running_crc ^ setup.final_xor);
          running_crc = setup.start_value;
        end
      end

      pending_o <= crc_expect_q.size();
    end
  end

endmodule

FILE: tb/crc32_multi_preset_engine_unit_tb.sv
`timescale 1ns / 100ps

module crc32_multi_preset_engine_unit_tb;

  // Mode codes beyond the six presets.
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int CycleLimit    = 400000;
  localparam int DataBeatGoal  = 1900;
  localparam int SettleCycles  = 4;
  localparam int TailCycles    = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_mode = c32mp_pkg::ModeIsoHdlc;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] crc_value;

  int pending;
  int fail_count;
  int crcs_checked;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int data_beats = 0;
  int mode_writes = 0;
  int send_pcts[4];
  int recv_pcts[4];
  int phase_goal;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crc32_multi_preset_engine_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_crc_mode_i (cfg_mode),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .has_byte_i     (has_byte),
    .last_item_i    (last_item),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .crc_value_o    (crc_value)
  );

  crc32_multi_preset_engine_unit_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_crc_mode_i (cfg_mode),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .has_byte_i     (has_byte),
    .last_item_i    (last_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .crc_value_i    (crc_value),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .checked_o      (crcs_checked)
  );

  // Result side back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("crc32_multi_preset_engine_unit test failed");
      $finish;
    end
  end

  // Present one input beat, with an optional random gap, and wait for acceptance.
  task automatic send_beat(input logic [7:0] b, input logic h, input logic l);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= h;
    last_item <= l;
    do @(posedge clk); while (!in_ready);
    if (h || l) data_beats++;
  endtask

  // Stop sending and wait until every predicted CRC has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mode writes happen only with the engine idle.
  task automatic write_mode(input logic [2:0] mode);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_mode  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // Byte values lean toward the all-zero and all-one corners.
  function automatic logic [7:0] pick_byte();
    int r;
    r = int'($urandom_range(15));
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // A message of len bytes, with stray empty beats, optionally closed by a beat that may add a byte.
  task automatic send_message(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(11) == 0) send_beat(pick_byte(), 1'b0, 1'b0);
      send_beat(pick_byte(), 1'b1, 1'b0);
    end
    if (close) send_beat(pick_byte(), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    send_pcts = '{0, 56, 0, 28};
    recv_pcts = '{0, 0, 56, 28};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset preset, empty message, corner bytes and an ignored beat.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b1);

    // Spare codes fall back to CD-ROM-EDC.
    write_mode(ModeSpare7);
    send_beat(8'h31, 1'b1, 1'b1);
    write_mode(ModeSpare6);
    send_beat(8'h00, 1'b0, 1'b1);

    // A mode write abandons the open message.
    write_mode(c32mp_pkg::ModeCdromEdc);
    send_beat(8'hFF, 1'b1, 1'b0);
    write_mode(c32mp_pkg::ModeMpeg2);
    send_beat(8'h00, 1'b0, 1'b1);

    // One closing beat with a byte under each remaining preset.
    write_mode(c32mp_pkg::ModeIscsi);
    send_beat(8'h7F, 1'b1, 1'b1);
    write_mode(c32mp_pkg::ModeBzip2);
    send_beat(8'h01, 1'b1, 1'b1);
    write_mode(c32mp_pkg::ModeJamcrc);
    send_beat(8'hFE, 1'b1, 1'b1);

    // Random messages in four idling phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      phase_goal     = data_beats + DataBeatGoal / 4;
      if (p == 2) drain_results();
      while (data_beats < phase_goal) begin
        if ($urandom_range(24) == 0) write_mode(3'($urandom_range(7)));
        send_message(($urandom_range(9) == 0) ? int'($urandom_range(64))
                                              : int'($urandom_range(8)),
                     $urandom_range(9) != 0);
      end
    end

    // Let the last results out.
    recv_stall_pct = 0;
    drain_results();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d input beats and %0d mode writes over all eight mode codes,",
             data_beats, mode_writes);
    $display("with %0d CRC results checked under four idling patterns.", crcs_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("crc32_multi_preset_engine_unit test passed");
    end else begin
      $display("crc32_multi_preset_engine_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/c32mp_pkg.sv
hw/rtl/c32mp_byte_update.sv
hw/rtl/c32mp_out_reg.sv
hw/rtl/crc32_multi_preset_engine_unit.sv
tb/crc32_multi_preset_engine_unit_checker.sv
tb/crc32_multi_preset_engine_unit_tb.sv
